// ===== rtl/ihist_pkg.sv =====
package ihist_pkg;

   localparam int COUNT_BITS   = 20;
   localparam int NUM_BINS     = 256;
   localparam int BIN_W        = $clog2(NUM_BINS);
   localparam int INTENSITY_W  = 17;
   localparam int HEIGHT_W     = 12;
   localparam int OUT_COUNT_W  = 20;
   localparam int PROD_W       = COUNT_BITS + HEIGHT_W;
   localparam int STEP_W       = $clog2(PROD_W + 1);
   localparam int BIN_SCALE    = 255;
   localparam int FRAC_BITS    = 16;
   localparam int SCALED_W     = INTENSITY_W + 8;

   localparam logic [HEIGHT_W-1:0]   PLOT_HEIGHT_RESET = HEIGHT_W'(384);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_QUERY  = 1'b1
   } kind_type;

   typedef struct packed {
      logic                   kind;
      logic [INTENSITY_W-1:0] intensity;
      logic [7:0]             query_bin;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]             bin_index;
      logic [OUT_COUNT_W-1:0] bin_count;
      logic                   bar_present;
      logic [HEIGHT_W-1:0]    bar_height;
      logic [OUT_COUNT_W-1:0] largest_count;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // floor(intensity * 255 / 65536), saturated to the last bin
   function automatic logic [BIN_W-1:0] bin_of(input logic [INTENSITY_W-1:0] intensity);
      logic [SCALED_W-1:0]          scaled;
      logic [SCALED_W-FRAC_BITS-1:0] raw;
      scaled = {intensity, 8'b0} - SCALED_W'(intensity);
      raw    = scaled[SCALED_W-1:FRAC_BITS];
      if (raw > (SCALED_W - FRAC_BITS)'(BIN_SCALE)) begin
         bin_of = BIN_W'(BIN_SCALE);
      end else begin
         bin_of = BIN_W'(raw);
      end
   endfunction

endpackage

// ===== rtl/ihist_ram.sv =====
module ihist_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ihist_div.sv =====
module ihist_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ihist_pkg::PROD_W-1:0]      dividend,
   input  logic [ihist_pkg::COUNT_BITS-1:0]  divisor,
   output logic [ihist_pkg::PROD_W-1:0]      quotient,
   output ihist_pkg::div_status_type         status
);
   import ihist_pkg::*;

   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0]     quo_ff, quo_in;
   logic [COUNT_BITS-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS:0]   shifted;
   logic [COUNT_BITS+1:0] trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, quo_ff[PROD_W-1]};
      trial   = {1'b0, shifted} - {2'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         step_in = STEP_W'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[COUNT_BITS+1]) begin
            rem_in = shifted[COUNT_BITS-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end else begin
            rem_in = trial[COUNT_BITS-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/intensity_histogram_bar_heights.sv =====
// 256-bin intensity histogram with scaled bar heights.
// req channel (valid/ready): kind 0 adds one Q1.16 intensity sample to bin
// floor(intensity*255/65536), saturating the bin counter; kind 1 queries
// query_bin. Only queries produce a transfer on the rsp channel, carrying the
// bin count, a nonzero flag, the bar height count*plot_height/largest and the
// largest count. csr channel writes plot_height and is always ready; write it
// only while the block is idle.
// One item at a time: a sample is accepted, then read-modify-writes its bin
// in the bin memory through its registered read port. A query is accepted,
// then passes a lookup state, a divider start state and a wait on the
// restoring divider (one quotient bit per cycle over the 32-bit product),
// which ends by collecting the quotient; the divider is skipped when the
// largest count is zero. req_ready returns the cycle after the rsp
// transfer, so no new request is taken before the last response is gone.
// Reset (synchronous, active high) clears all bins through per-bin valid
// flags at once, clears the largest count and sets plot_height to 384; no
// clearing pass is needed. A result holds in the output register until the
// receiver takes it; req_ready stays low meanwhile.
module intensity_histogram_bar_heights (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ihist_pkg::req_payload_type      req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ihist_pkg::rsp_payload_type      rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ihist_pkg::HEIGHT_W-1:0]  csr_data
);
   import ihist_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_LOOK      = 5'b00010,
      ST_DIV_START = 5'b00100,
      ST_DIV_WAIT  = 5'b01000,
      ST_RESP      = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [NUM_BINS-1:0]   valid_ff, valid_in;
   logic [COUNT_BITS-1:0] peak_ff, peak_in;
   logic [HEIGHT_W-1:0]   plot_height_ff, plot_height_in;
   logic                  kind_ff, kind_in;
   logic [BIN_W-1:0]      bin_ff, bin_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [HEIGHT_W-1:0]   height_ff, height_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic                  req_fire;
   logic [BIN_W-1:0]      req_bin;
   logic [COUNT_BITS-1:0] ram_rdata;
   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] inc_count;
   logic                  ram_we;
   logic                  div_start;
   logic [PROD_W-1:0]     div_quotient;
   div_status_type        div_status;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   assign req_bin   = (req_data.kind == KIND_QUERY) ? req_data.query_bin
                                                    : bin_of(req_data.intensity);
   // a bin never written since reset reads as zero
   assign cur_count = valid_ff[bin_ff] ? ram_rdata : '0;
   assign inc_count = (cur_count == COUNT_MAX) ? cur_count
                                               : cur_count + COUNT_BITS'(1);
   assign ram_we    = (state_ff == ST_LOOK) && (kind_ff == KIND_SAMPLE);
   assign div_start = (state_ff == ST_DIV_START);

   ihist_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (bin_ff),
      .wr_data (inc_count),
      .rd_en   (req_fire),
      .rd_addr (req_bin),
      .rd_data (ram_rdata)
   );

   ihist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (peak_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      peak_in        = peak_ff;
      plot_height_in = plot_height_ff;
      kind_in        = kind_ff;
      bin_in         = bin_ff;
      cnt_in         = cnt_ff;
      prod_in        = prod_ff;
      height_in      = height_ff;
      rsp_in         = rsp_ff;

      if (csr_valid && csr_ready) begin
         plot_height_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_data.kind;
               bin_in   = req_bin;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (kind_ff == KIND_SAMPLE) begin
               valid_in[bin_ff] = 1'b1;
               if (inc_count > peak_ff) begin
                  peak_in = inc_count;
               end
               state_in = ST_IDLE;
            end else begin
               cnt_in  = cur_count;
               prod_in = PROD_W'(cur_count) * PROD_W'(plot_height_ff);
               if (peak_ff == '0) begin
                  height_in = '0;
                  state_in  = ST_RESP;
               end else begin
                  state_in  = ST_DIV_START;
               end
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               height_in = div_quotient[HEIGHT_W-1:0];
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result register loads as the query enters the response state
      if (state_ff != ST_RESP && state_in == ST_RESP) begin
         rsp_in.bin_index     = bin_ff;
         rsp_in.bin_count     = OUT_COUNT_W'(cnt_in);
         rsp_in.bar_present   = (cnt_in != '0);
         rsp_in.bar_height    = height_in;
         rsp_in.largest_count = OUT_COUNT_W'(peak_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         peak_ff        <= '0;
         plot_height_ff <= PLOT_HEIGHT_RESET;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         peak_ff        <= peak_in;
         plot_height_ff <= plot_height_in;
      end
      kind_ff   <= kind_in;
      bin_ff    <= bin_in;
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      height_ff <= height_in;
      rsp_ff    <= rsp_in;
   end

endmodule
